// ----- hw/rtl/qte_pkg.sv -----
// Shared types, constants and the CORDIC angle table for the quaternion to
// Euler angle converter. No dependencies.
`default_nettype none
package qte_pkg;

   localparam int QUAT_WIDTH_DEF    = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int CW       = 40;   // CORDIC vector width, Q.30
   localparam int ZW       = 36;   // angle width, Q.29
   localparam int SW       = 32;   // asin argument width, Q.30
   localparam int NW       = 62;   // square root working width
   localparam int SQ_STEPS = 31;   // one result bit per cell
   localparam int LANES    = 3;    // heading, attitude, bank
   localparam int TAB_LEN  = 24;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [ZW-1:0] angle_type;
   typedef logic [1:0]           pole_type;

   localparam pole_type POLE_NONE  = 2'd0;
   localparam pole_type POLE_NORTH = 2'd1;
   localparam pole_type POLE_SOUTH = 2'd2;

   localparam logic REG_POLE_THR = 1'b0;

   localparam angle_type PI_Q29      = 36'sd1686629713;
   localparam angle_type HALF_PI_Q29 = 36'sd843314857;

   // sideband that rides along the square root cells
   typedef struct packed {
      pole_type           pc;
      coord_type          hx;
      coord_type          hy;
      coord_type          bx;
      coord_type          by;
      logic signed [SW-1:0] s;
   } sqrt_side_type;

   // sideband that rides along the CORDIC cells
   typedef struct packed {
      pole_type         pc;
      logic [LANES-1:0] zero;
   } cordic_side_type;

   // atan(2^-i) in Q.29, rounded to nearest
   function automatic angle_type atan_entry(input int i);
      angle_type a;
      case (i)
         0: a = 36'sd421657428;
         1: a = 36'sd248918915;
         2: a = 36'sd131521918;
         3: a = 36'sd66762579;
         4: a = 36'sd33510843;
         5: a = 36'sd16771758;
         6: a = 36'sd8387925;
         7: a = 36'sd4194219;
         8: a = 36'sd2097141;
         9: a = 36'sd1048575;
         10: a = 36'sd524288;
         11: a = 36'sd262144;
         12: a = 36'sd131072;
         13: a = 36'sd65536;
         14: a = 36'sd32768;
         15: a = 36'sd16384;
         16: a = 36'sd8192;
         17: a = 36'sd4096;
         18: a = 36'sd2048;
         19: a = 36'sd1024;
         20: a = 36'sd512;
         21: a = 36'sd256;
         22: a = 36'sd128;
         23: a = 36'sd64;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/qte_sqrt_cell.sv -----
// One cell of the square root row: settles one result bit per request.
// Depends on qte_pkg.
`default_nettype none
module qte_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   src_valid,
   input  logic [qte_pkg::NW-1:0] src_rem,
   input  logic [qte_pkg::NW-1:0] src_root,
   input  qte_pkg::sqrt_side_type src_side,
   output logic                   dst_valid,
   output logic [qte_pkg::NW-1:0] dst_rem,
   output logic [qte_pkg::NW-1:0] dst_root,
   output qte_pkg::sqrt_side_type dst_side
);
   import qte_pkg::*;

   localparam logic [NW-1:0] BIT = NW'(1) << (2 * STEP);

   logic [NW-1:0] trial;
   logic [NW-1:0] rem_in, root_in;
   logic          valid_ff;
   logic [NW-1:0] rem_ff, root_ff;
   sqrt_side_type side_ff;

   assign trial = src_root + BIT;

   always_comb begin
      if (src_rem >= trial) begin
         rem_in  = src_rem - trial;
         root_in = (src_root >> 1) + BIT;
      end else begin
         rem_in  = src_rem;
         root_in = src_root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= src_side;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_rem   = rem_ff;
   assign dst_root  = root_ff;
   assign dst_side  = side_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/qte_cordic_cell.sv -----
// One vectoring CORDIC stage for the three angle lanes.
// Depends on qte_pkg.
`default_nettype none
module qte_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     src_valid,
   input  qte_pkg::coord_type       src_x [qte_pkg::LANES],
   input  qte_pkg::coord_type       src_y [qte_pkg::LANES],
   input  qte_pkg::angle_type       src_z [qte_pkg::LANES],
   input  qte_pkg::cordic_side_type src_side,
   output logic                     dst_valid,
   output qte_pkg::coord_type       dst_x [qte_pkg::LANES],
   output qte_pkg::coord_type       dst_y [qte_pkg::LANES],
   output qte_pkg::angle_type       dst_z [qte_pkg::LANES],
   output qte_pkg::cordic_side_type dst_side
);
   import qte_pkg::*;

   localparam angle_type ANG = atan_entry(STAGE);

   coord_type       x_in [LANES];
   coord_type       y_in [LANES];
   angle_type       z_in [LANES];
   coord_type       x_ff [LANES];
   coord_type       y_ff [LANES];
   angle_type       z_ff [LANES];
   logic            valid_ff;
   cordic_side_type side_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (!src_y[l][CW-1]) begin
            x_in[l] = src_x[l] + (src_y[l] >>> STAGE);
            y_in[l] = src_y[l] - (src_x[l] >>> STAGE);
            z_in[l] = src_z[l] + ANG;
         end else begin
            x_in[l] = src_x[l] - (src_y[l] >>> STAGE);
            y_in[l] = src_y[l] + (src_x[l] >>> STAGE);
            z_in[l] = src_z[l] - ANG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= src_side;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_x     = x_ff;
   assign dst_y     = y_ff;
   assign dst_z     = z_ff;
   assign dst_side  = side_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/quat_to_euler_angles.sv -----
// Quaternion to heading/attitude/bank converter, top level.
// Depends on qte_pkg, qte_sqrt_cell and qte_cordic_cell.
//
//  channel | dir | payload
//  req_    | in  | tdata: quat_x, quat_y, quat_z, quat_w
//  rsp_    | out | tdata: heading, attitude, bank; tuser: pole_case
//  csr_    | in  | APB, pole_threshold at byte address 0
//
// One request per cycle while rsp_ does not stall. The row holds capture,
// product, sum and cosine-square stages, one square root cell per result bit,
// a quadrant stage, one cell per CORDIC stage and the output register.
// A stall on rsp_ holds the whole row; reset empties it.
`default_nettype none
module quat_to_euler_angles #(
   parameter int QUAT_WIDTH    = qte_pkg::QUAT_WIDTH_DEF,
   parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // quat_x, quat_y, quat_z, quat_w from bit 0 up
   input  logic [((4*QUAT_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // heading[16:0], attitude[31:17], bank[47:32]
   output logic [47:0] rsp_tdata,
   // pole_case
   output logic [1:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import qte_pkg::*;

   localparam int Q      = QUAT_WIDTH;
   localparam int F      = Q - 1;
   localparam int SC     = 2 * F - 2;
   localparam int XW     = 2 * Q + 34;
   localparam int F_SHL  = (F >= 30) ? 0 : 30 - F;
   localparam int F_SHR  = (F >= 30) ? F - 30 : 0;
   localparam int SC_SHL = (SC >= 30) ? 0 : 30 - SC;
   localparam int SC_SHR = (SC >= 30) ? SC - 30 : 0;
   localparam int THR_SHL = 2 * F - 16;
   localparam int RW     = ZW + 2;

   typedef logic signed [Q-1:0]   quat_type;
   typedef logic signed [2*Q-1:0] prod_type;
   typedef logic signed [XW-1:0]  wide_type;
   typedef logic signed [RW-1:0]  round_type;

   localparam wide_type  ONE_Q30  = wide_type'(64'sd1073741824);
   localparam round_type HALF_LSB = round_type'(32768);

   // ---- configuration
   logic [14:0] thr_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_POLE_THR) ? {17'd0, thr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 15'd16351;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_POLE_THR) begin
         thr_ff <= csr_pwdata[14:0];
      end
   end

   // ---- flow control: the row moves whenever the output register frees up
   logic adv;
   logic rsp_valid_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // ---- stage 1: capture
   logic     s1_valid_ff;
   quat_type qx_ff, qy_ff, qz_ff, qw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff <= req_tdata[Q-1:0];
         qy_ff <= req_tdata[2*Q-1:Q];
         qz_ff <= req_tdata[3*Q-1:2*Q];
         qw_ff <= req_tdata[4*Q-1:3*Q];
      end
   end

   // ---- stage 2: products
   logic     s2_valid_ff;
   prod_type p_xy_ff, p_zw_ff, p_yw_ff, p_xz_ff, p_yy_ff;
   prod_type p_zz_ff, p_xw_ff, p_yz_ff, p_xx_ff;
   quat_type qx2_ff, qw2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_xy_ff <= qx_ff * qy_ff;
         p_zw_ff <= qz_ff * qw_ff;
         p_yw_ff <= qy_ff * qw_ff;
         p_xz_ff <= qx_ff * qz_ff;
         p_yy_ff <= qy_ff * qy_ff;
         p_zz_ff <= qz_ff * qz_ff;
         p_xw_ff <= qx_ff * qw_ff;
         p_yz_ff <= qy_ff * qz_ff;
         p_xx_ff <= qx_ff * qx_ff;
         qx2_ff  <= qx_ff;
         qw2_ff  <= qw_ff;
      end
   end

   // ---- stage 3: sums, pole test, asin argument
   wide_type t, thr, hn, hs, bn, bs, t30, hn30, hd, bn30, bd, qx30, qw30, s_cl;
   pole_type pc_in;
   sqrt_side_type s3_side_in, s3_side_ff;
   logic     s3_valid_ff;

   always_comb begin
      t    = (wide_type'(p_xy_ff) >>> 1) + (wide_type'(p_zw_ff) >>> 1);
      thr  = wide_type'({1'b0, thr_ff}) <<< THR_SHL;
      hn   = (wide_type'(p_yw_ff) >>> 1) - (wide_type'(p_xz_ff) >>> 1);
      hs   = (wide_type'(p_yy_ff) >>> 1) + (wide_type'(p_zz_ff) >>> 1);
      bn   = (wide_type'(p_xw_ff) >>> 1) - (wide_type'(p_yz_ff) >>> 1);
      bs   = (wide_type'(p_xx_ff) >>> 1) + (wide_type'(p_zz_ff) >>> 1);
      t30  = (t  <<< SC_SHL) >>> SC_SHR;
      hn30 = (hn <<< SC_SHL) >>> SC_SHR;
      bn30 = (bn <<< SC_SHL) >>> SC_SHR;
      hd   = ONE_Q30 - ((hs <<< SC_SHL) >>> SC_SHR);
      bd   = ONE_Q30 - ((bs <<< SC_SHL) >>> SC_SHR);
      qx30 = (wide_type'(qx2_ff) <<< F_SHL) >>> F_SHR;
      qw30 = (wide_type'(qw2_ff) <<< F_SHL) >>> F_SHR;
      if (t30 > ONE_Q30) begin
         s_cl = ONE_Q30;
      end else if (t30 < -ONE_Q30) begin
         s_cl = -ONE_Q30;
      end else begin
         s_cl = t30;
      end
      if (t > thr) begin
         pc_in = POLE_NORTH;
      end else if (t < -thr) begin
         pc_in = POLE_SOUTH;
      end else begin
         pc_in = POLE_NONE;
      end
      s3_side_in.pc = pc_in;
      // in a pole case the heading lane works on atan2(x, w)
      if (pc_in != POLE_NONE) begin
         s3_side_in.hy = coord_type'(qx30);
         s3_side_in.hx = coord_type'(qw30);
      end else begin
         s3_side_in.hy = coord_type'(hn30);
         s3_side_in.hx = coord_type'(hd);
      end
      s3_side_in.by = coord_type'(bn30);
      s3_side_in.bx = coord_type'(bd);
      s3_side_in.s  = SW'(s_cl);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_side_ff <= s3_side_in;
      end
   end

   // ---- stage 4: 1 - s^2 in Q.60
   logic signed [2*SW-1:0] s_sq;
   logic [NW-1:0] sq_rem [SQ_STEPS+1];
   logic [NW-1:0] sq_root [SQ_STEPS+1];
   logic          sq_valid [SQ_STEPS+1];
   sqrt_side_type sq_side [SQ_STEPS+1];
   logic [NW-1:0] c2_ff;
   logic          s4_valid_ff;
   sqrt_side_type s4_side_ff;

   assign s_sq = s3_side_ff.s * s3_side_ff.s;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c2_ff      <= (NW'(1) << 60) - NW'(s_sq);
         s4_side_ff <= s3_side_ff;
      end
   end

   assign sq_valid[0] = s4_valid_ff;
   assign sq_rem[0]   = c2_ff;
   assign sq_root[0]  = '0;
   assign sq_side[0]  = s4_side_ff;

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
      qte_sqrt_cell #(.STEP(SQ_STEPS - 1 - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .src_valid (sq_valid[i]),
         .src_rem   (sq_rem[i]),
         .src_root  (sq_root[i]),
         .src_side  (sq_side[i]),
         .dst_valid (sq_valid[i+1]),
         .dst_rem   (sq_rem[i+1]),
         .dst_root  (sq_root[i+1]),
         .dst_side  (sq_side[i+1])
      );
   end

   // ---- quadrant stage: turn left half-plane vectors by pi
   coord_type       px [LANES];
   coord_type       py [LANES];
   coord_type       cx [CORDIC_STAGES+1][LANES];
   coord_type       cy [CORDIC_STAGES+1][LANES];
   angle_type       cz [CORDIC_STAGES+1][LANES];
   logic            cv [CORDIC_STAGES+1];
   cordic_side_type cs [CORDIC_STAGES+1];
   coord_type       qx_in [LANES];
   coord_type       qy_in [LANES];
   angle_type       qz_in [LANES];
   logic [LANES-1:0] zero_in;
   sqrt_side_type   sq_last;

   assign sq_last = sq_side[SQ_STEPS];

   always_comb begin
      py[0] = sq_last.hy;
      px[0] = sq_last.hx;
      py[1] = coord_type'(sq_last.s);
      px[1] = coord_type'(sq_root[SQ_STEPS]);
      py[2] = sq_last.by;
      px[2] = sq_last.bx;
      for (int l = 0; l < LANES; l++) begin
         zero_in[l] = (px[l] == '0) && (py[l] == '0);
         if (px[l][CW-1]) begin
            qx_in[l] = -px[l];
            qy_in[l] = -py[l];
            qz_in[l] = py[l][CW-1] ? -PI_Q29 : PI_Q29;
         end else begin
            qx_in[l] = px[l];
            qy_in[l] = py[l];
            qz_in[l] = '0;
         end
      end
   end

   logic            pre_valid_ff;
   coord_type       pre_x_ff [LANES];
   coord_type       pre_y_ff [LANES];
   angle_type       pre_z_ff [LANES];
   cordic_side_type pre_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (adv) begin
         pre_valid_ff <= sq_valid[SQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_x_ff         <= qx_in;
         pre_y_ff         <= qy_in;
         pre_z_ff         <= qz_in;
         pre_side_ff.pc   <= sq_last.pc;
         pre_side_ff.zero <= zero_in;
      end
   end

   assign cv[0] = pre_valid_ff;
   assign cx[0] = pre_x_ff;
   assign cy[0] = pre_y_ff;
   assign cz[0] = pre_z_ff;
   assign cs[0] = pre_side_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      qte_cordic_cell #(.STAGE(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .src_valid (cv[i]),
         .src_x     (cx[i]),
         .src_y     (cy[i]),
         .src_z     (cz[i]),
         .src_side  (cs[i]),
         .dst_valid (cv[i+1]),
         .dst_x     (cx[i+1]),
         .dst_y     (cy[i+1]),
         .dst_z     (cz[i+1]),
         .dst_side  (cs[i+1])
      );
   end

   // ---- output stage: clamp, round to Q.13, pick the case
   function automatic angle_type clamp_ang(input angle_type v, input angle_type lim);
      angle_type r;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic round_type to_q13(input round_type v);
      round_type r;
      r = (v + HALF_LSB) >>> 16;
      return r;
   endfunction

   angle_type       za [LANES];
   cordic_side_type last_side;
   round_type       r_head, r_att, r_bank, pole_a;
   logic [47:0]     data_in;
   logic [47:0]     rsp_data_ff;
   pole_type        rsp_pc_ff;

   assign last_side = cs[CORDIC_STAGES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         za[l] = last_side.zero[l] ? '0 : cz[CORDIC_STAGES][l];
      end
      pole_a = round_type'(za[0]) <<< 1;
      case (last_side.pc)
         POLE_NORTH: begin
            r_head = to_q13(pole_a);
            r_att  = to_q13(round_type'(HALF_PI_Q29));
            r_bank = '0;
         end
         POLE_SOUTH: begin
            r_head = to_q13(-pole_a);
            r_att  = to_q13(-round_type'(HALF_PI_Q29));
            r_bank = '0;
         end
         default: begin
            r_head = to_q13(round_type'(clamp_ang(za[0], PI_Q29)));
            r_att  = to_q13(round_type'(clamp_ang(za[1], HALF_PI_Q29)));
            r_bank = to_q13(round_type'(clamp_ang(za[2], PI_Q29)));
         end
      endcase
      data_in = {r_bank[15:0], r_att[14:0], r_head[16:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= cv[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= data_in;
         rsp_pc_ff   <= last_side.pc;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_pc_ff;

endmodule
`default_nettype wire

// ----- tb/tb_quat_to_euler_angles.sv -----
// Testbench for quat_to_euler_angles: streams quaternions in, predicts heading,
// attitude, bank and pole case, and checks every response in order.
// Depends on qte_pkg and the RTL of quat_to_euler_angles.
`timescale 1ns / 100ps
module tb_quat_to_euler_angles;
   import qte_pkg::*;

   localparam longint PI_FIX   = 64'sd1686629713;
   localparam longint HALF_FIX = 64'sd843314857;
   localparam longint ONE_FIX  = 64'sd1073741824;
   localparam int     DRAIN    = 60;
   localparam int     LIMIT    = 400000;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic signed [15:0] w;
   } quat_type;

   typedef struct packed {
      logic [16:0] heading;
      logic [14:0] attitude;
      logic [15:0] bank;
      pole_type    pc;
   } euler_type;

   // atan(2^-i), Q.29
   localparam longint ATAN_LUT [16] = '{
      421657428, 248918915, 131521918, 66762579, 33510843, 16771758, 8387925,
      4194219, 2097141, 1048575, 524288, 262144, 131072, 65536, 32768, 16384};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // quat_x, quat_y, quat_z, quat_w
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // heading, attitude, bank
   logic [1:0]  rsp_tuser;        // pole_case
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [14:0] thr_shadow = 15'd16351;
   euler_type   angles_due[$];
   int          errors = 0;
   int          n_checked = 0;
   int          n_north = 0;
   int          n_south = 0;
   int          cycles = 0;
   bit          calm = 1'b0;

   quat_to_euler_angles i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint vec_angle(longint yv, longint xv);
      longint x, y, z, dx, dy;
      x = xv; y = yv; z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? PI_FIX : -PI_FIX;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_LUT[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_LUT[i];
         end
      end
      return z;
   endfunction

   function automatic longint lim(longint v, longint m);
      if (v > m) return m;
      if (v < -m) return -m;
      return v;
   endfunction

   function automatic longint to_q13(longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned res, b;
      res = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic euler_type predict_angles(quat_type q, logic [14:0] thr_reg);
      longint qx, qy, qz, qw, t, thr, a, hn, hd, bn, bd, s, c;
      longint hd_v, at_v, bk_v;
      longint unsigned c2;
      euler_type e;
      qx = q.x; qy = q.y; qz = q.z; qw = q.w;
      t = ((qx * qy) >>> 1) + ((qz * qw) >>> 1);
      thr = longint'(thr_reg) <<< 14;
      if (t > thr || t < -thr) begin
         a = vec_angle(qx <<< 15, qw <<< 15);
         e.pc = (t > thr) ? POLE_NORTH : POLE_SOUTH;
         hd_v = to_q13(e.pc == POLE_NORTH ? 2 * a : -2 * a);
         at_v = to_q13(e.pc == POLE_NORTH ? HALF_FIX : -HALF_FIX);
         bk_v = 0;
      end else begin
         hn = ((qy * qw) >>> 1) - ((qx * qz) >>> 1);
         hd = ONE_FIX - ((((qy * qy) >>> 1) + ((qz * qz) >>> 1)) <<< 2);
         bn = ((qx * qw) >>> 1) - ((qy * qz) >>> 1);
         bd = ONE_FIX - ((((qx * qx) >>> 1) + ((qz * qz) >>> 1)) <<< 2);
         s = lim(t <<< 2, ONE_FIX);
         c2 = longint'(ONE_FIX * ONE_FIX) - longint'(s * s);
         c = longint'(root_floor(c2));
         e.pc = POLE_NONE;
         hd_v = to_q13(lim(vec_angle(hn <<< 2, hd), PI_FIX));
         at_v = to_q13(lim(vec_angle(s, c), HALF_FIX));
         bk_v = to_q13(lim(vec_angle(bn <<< 2, bd), PI_FIX));
      end
      e.heading = hd_v[16:0];
      e.attitude = at_v[14:0];
      e.bank = bk_v[15:0];
      return e;
   endfunction

   // send one request; valid stays up unless the sender idles afterwards
   task automatic send_quat(quat_type q);
      req_tdata <= {q.w, q.z, q.y, q.x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      angles_due.push_back(predict_angles(q, thr_shadow));
      if (!calm && $urandom_range(0, 99) < 9) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (angles_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_threshold(logic [31:0] val);
      wait_idle();
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= 3'(REG_POLE_THR) * 3'd4;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      thr_shadow = val[14:0];
      @(posedge clock);
   endtask

   function automatic quat_type from_real(real x, real y, real z, real w);
      real n;
      quat_type q;
      n = $sqrt(x * x + y * y + z * z + w * w);
      if (n == 0.0) n = 1.0;
      q.x = 16'($rtoi(x / n * 32767.0));
      q.y = 16'($rtoi(y / n * 32767.0));
      q.z = 16'($rtoi(z / n * 32767.0));
      q.w = 16'($rtoi(w / n * 32767.0));
      return q;
   endfunction

   function automatic real rnd_unit();
      return ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
   endfunction

   function automatic quat_type rnd_quat();
      return from_real(rnd_unit(), rnd_unit(), rnd_unit(), rnd_unit());
   endfunction

   function automatic quat_type rnd_raw();
      quat_type q;
      q = {$urandom, $urandom};
      return q;
   endfunction

   // near a pole: y = +-x and w = +-z (same sign) give t close to plus or minus one half
   function automatic quat_type rnd_pole();
      real a, b, sy;
      a = 1.0 + rnd_unit() * 0.02;
      b = 1.0 + rnd_unit() * 0.02;
      sy = ($urandom_range(0, 1) != 0) ? 1.0 : -1.0;
      return from_real(a, sy * a, b, sy * b);
   endfunction

   task automatic test_extremes();
      quat_type q;
      send_quat('0);
      send_quat({16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
      send_quat({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
      send_quat({16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF});
      send_quat({16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000});
      send_quat({16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000});
      send_quat({16'sh0000, 16'sh8000, 16'sh0000, 16'sh0000});
      send_quat({16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000});
      send_quat({16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
      send_quat({16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000});
      send_quat({16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000});
      send_quat({16'sh4000, 16'shC000, 16'sh4000, 16'shC000});
      send_quat({16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh0000});
      q = from_real(1.0, 0.0, 0.0, 1.0);
      send_quat(q);
      q = from_real(0.0, 1.0, 0.0, -1.0);
      send_quat(q);
   endtask

   task automatic test_pole_regions();
      for (int i = 0; i < 150; i++) send_quat(rnd_pole());
   endtask

   task automatic test_random_unit(int count);
      for (int i = 0; i < count; i++) send_quat(rnd_quat());
   endtask

   task automatic test_random_mixed(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 9);
         if (r < 6) send_quat(rnd_quat());
         else if (r < 8) send_quat(rnd_pole());
         else send_quat(rnd_raw());
      end
   endtask

   task automatic test_threshold_settings();
      write_threshold(32'd0);
      test_random_mixed(120);
      write_threshold(32'd16384);
      test_random_mixed(120);
      write_threshold(32'hFFFF_FFFF);   // upper bits dropped, poles only from raw inputs
      test_random_mixed(80);
      write_threshold(32'd16300);
      test_pole_regions();
      write_threshold($urandom_range(0, 16384));
      test_random_mixed(120);
      write_threshold(32'd16351);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (calm) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 99) >= 18);
   end

   always @(posedge clock) begin
      euler_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (angles_due.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            want = angles_due.pop_front();
            n_checked++;
            if (want.pc == POLE_NORTH) n_north++;
            if (want.pc == POLE_SOUTH) n_south++;
            if (rsp_tdata[16:0] !== want.heading) begin
               $error("heading: expected %0d, got %0d", $signed(want.heading),
                      $signed(rsp_tdata[16:0]));
               errors++;
            end
            if (rsp_tdata[31:17] !== want.attitude) begin
               $error("attitude: expected %0d, got %0d", $signed(want.attitude),
                      $signed(rsp_tdata[31:17]));
               errors++;
            end
            if (rsp_tdata[47:32] !== want.bank) begin
               $error("bank: expected %0d, got %0d", $signed(want.bank),
                      $signed(rsp_tdata[47:32]));
               errors++;
            end
            if (rsp_tuser !== want.pc) begin
               $error("pole_case: expected %0d, got %0d", want.pc, rsp_tuser);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout with %0d responses outstanding", angles_due.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_pole_regions();
      test_random_unit(300);
      calm = 1'b1;
      test_random_mixed(200);
      calm = 1'b0;
      test_threshold_settings();
      test_random_mixed(700);
      wait_idle();
      if (angles_due.size() != 0) begin
         $error("%0d responses never arrived", angles_due.size());
         errors++;
      end
      $display("checked %0d responses (%0d north pole, %0d south pole), thresholds",
               n_checked, n_north, n_south);
      $display("from 0 to 16384 plus an oversized write, with random stalls on both sides");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- quat_to_euler_angles.f -----
hw/rtl/qte_pkg.sv
hw/rtl/qte_sqrt_cell.sv
hw/rtl/qte_cordic_cell.sv
hw/rtl/quat_to_euler_angles.sv
tb/tb_quat_to_euler_angles.sv
